// File: design/pdp_pkg.sv
package pdp_pkg;

  localparam int QDEPTH = 4;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MODS    = 3'd1;
  localparam logic [2:0] PH_DIGITS  = 3'd2;
  localparam logic [2:0] PH_COMMENT = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNSUP     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_BANG      = 3'd3;
  localparam logic [2:0] ST_DBL_ORDER = 3'd4;
  localparam logic [2:0] ST_TOO_BIG   = 3'd5;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_SPACE   = 5'd1;
  localparam logic [4:0] K_COMMENT = 5'd2;
  localparam logic [4:0] K_INT     = 5'd3;
  localparam logic [4:0] K_UTF8    = 5'd4;
  localparam logic [4:0] K_BER     = 5'd5;
  localparam logic [4:0] K_FLOAT   = 5'd6;
  localparam logic [4:0] K_SPSTR   = 5'd7;
  localparam logic [4:0] K_NULSTR  = 5'd8;
  localparam logic [4:0] K_ZSTR    = 5'd9;
  localparam logic [4:0] K_BITSM   = 5'd10;
  localparam logic [4:0] K_BITSL   = 5'd11;
  localparam logic [4:0] K_HEXH    = 5'd12;
  localparam logic [4:0] K_HEXL    = 5'd13;
  localparam logic [4:0] K_UU      = 5'd14;
  localparam logic [4:0] K_MIME    = 5'd15;
  localparam logic [4:0] K_B64     = 5'd16;
  localparam logic [4:0] K_FIXSTR  = 5'd17;
  localparam logic [4:0] K_PTR     = 5'd18;
  localparam logic [4:0] K_MOVE    = 5'd19;
  localparam logic [4:0] K_BACK    = 5'd20;
  localparam logic [4:0] K_NULL    = 5'd21;

  localparam logic [1:0] SG_NA = 2'd0;
  localparam logic [1:0] SG_U  = 2'd1;
  localparam logic [1:0] SG_S  = 2'd2;

  localparam logic [2:0] BO_NA     = 3'd0;
  localparam logic [2:0] BO_AGN    = 3'd1;
  localparam logic [2:0] BO_NATIVE = 3'd2;
  localparam logic [2:0] BO_LITTLE = 3'd3;
  localparam logic [2:0] BO_BIG    = 3'd4;

  localparam logic [3:0] W_NA    = 4'd0;
  localparam logic [3:0] W_8     = 4'd1;
  localparam logic [3:0] W_16    = 4'd2;
  localparam logic [3:0] W_32    = 4'd3;
  localparam logic [3:0] W_64    = 4'd4;
  localparam logic [3:0] W_PTR   = 4'd5;
  localparam logic [3:0] W_INT   = 4'd6;
  localparam logic [3:0] W_SHORT = 4'd7;
  localparam logic [3:0] W_LONG  = 4'd8;
  localparam logic [3:0] W_LL    = 4'd9;

  localparam logic [1:0] CK_NA    = 2'd0;
  localparam logic [1:0] CK_FIXED = 2'd1;
  localparam logic [1:0] CK_MAX   = 2'd2;
  localparam logic [1:0] CK_REL   = 2'd3;

  localparam logic [1:0] ENC_START = 2'd0;
  localparam logic [1:0] ENC_ASCII = 2'd1;
  localparam logic [1:0] ENC_UTF8  = 2'd2;
  localparam logic [1:0] ENC_BIN   = 2'd3;

  localparam logic [63:0] CNT_LIMIT = 64'd1844674407370955161;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  kind;
    logic [1:0]  signedness;
    logic [2:0]  byte_order;
    logic [3:0]  width_code;
    logic [1:0]  count_kind;
    logic [63:0] count;
    logic [1:0]  encoding;
  } desc_t;

  typedef struct packed {
    desc_t d0;
    desc_t d1;
    logic  two;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] k;
    logic [1:0] s;
    logic [2:0] b;
    logic [3:0] w;
    logic       f;
  } lk_t;

  function automatic lk_t lookup(input logic [7:0] c);
    lk_t r;
    r = '{ok: 1'b1, k: K_END, s: SG_NA, b: BO_NA, w: W_NA, f: 1'b0};
    case (c)
      "C": r = '{1'b1, K_INT, SG_U, BO_AGN, W_8, 1'b0};
      "S": r = '{1'b1, K_INT, SG_U, BO_NATIVE, W_16, 1'b0};
      "L": r = '{1'b1, K_INT, SG_U, BO_NATIVE, W_32, 1'b0};
      "Q": r = '{1'b1, K_INT, SG_U, BO_NATIVE, W_64, 1'b0};
      "J": r = '{1'b1, K_INT, SG_U, BO_NATIVE, W_PTR, 1'b0};
      "c": r = '{1'b1, K_INT, SG_S, BO_AGN, W_8, 1'b0};
      "s": r = '{1'b1, K_INT, SG_S, BO_NATIVE, W_16, 1'b0};
      "l": r = '{1'b1, K_INT, SG_S, BO_NATIVE, W_32, 1'b0};
      "q": r = '{1'b1, K_INT, SG_S, BO_NATIVE, W_64, 1'b0};
      "j": r = '{1'b1, K_INT, SG_S, BO_NATIVE, W_PTR, 1'b0};
      "I": r = '{1'b1, K_INT, SG_U, BO_NATIVE, W_INT, 1'b0};
      "i": r = '{1'b1, K_INT, SG_S, BO_NATIVE, W_INT, 1'b0};
      "n": r = '{1'b1, K_INT, SG_U, BO_BIG, W_16, 1'b1};
      "N": r = '{1'b1, K_INT, SG_U, BO_BIG, W_32, 1'b1};
      "v": r = '{1'b1, K_INT, SG_U, BO_LITTLE, W_16, 1'b1};
      "V": r = '{1'b1, K_INT, SG_U, BO_LITTLE, W_32, 1'b1};
      "U": r.k = K_UTF8;
      "w": r.k = K_BER;
      "D", "d": r = '{1'b1, K_FLOAT, SG_NA, BO_NATIVE, W_64, 1'b0};
      "F", "f": r = '{1'b1, K_FLOAT, SG_NA, BO_NATIVE, W_32, 1'b0};
      "E": r = '{1'b1, K_FLOAT, SG_NA, BO_LITTLE, W_64, 1'b0};
      "e": r = '{1'b1, K_FLOAT, SG_NA, BO_LITTLE, W_32, 1'b0};
      "G": r = '{1'b1, K_FLOAT, SG_NA, BO_BIG, W_64, 1'b0};
      "g": r = '{1'b1, K_FLOAT, SG_NA, BO_BIG, W_32, 1'b0};
      "A": r.k = K_SPSTR;
      "a": r.k = K_NULSTR;
      "Z": r.k = K_ZSTR;
      "B": r.k = K_BITSM;
      "b": r.k = K_BITSL;
      "H": r.k = K_HEXH;
      "h": r.k = K_HEXL;
      "u": r.k = K_UU;
      "M": r.k = K_MIME;
      "m": r.k = K_B64;
      "P": r.k = K_FIXSTR;
      "p": r.k = K_PTR;
      "@": r.k = K_MOVE;
      "X": r.k = K_BACK;
      "x": r.k = K_NULL;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic desc_t mk(input logic [2:0] st, input logic [4:0] k,
                               input logic [1:0] sg, input logic [2:0] bo,
                               input logic [3:0] wc, input logic [1:0] ck,
                               input logic [63:0] cnt, input logic [1:0] enc);
    desc_t d;
    d = '{st, k, sg, bo, wc, ck, cnt, enc};
    return d;
  endfunction

endpackage

// File: design/pdp_front.sv
module pdp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              acc,
  input  logic              cmd,
  input  logic [7:0]        ch,
  output logic              push,
  output pdp_pkg::entry_t   push_ent
);

  logic        mode_r;
  logic [2:0]  ph_r, ph_nxt;
  logic [4:0]  hk_r, hk_nxt;
  logic [1:0]  hs_r, hs_nxt;
  logic [2:0]  hb_r, hb_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [1:0]  hck_r, hck_nxt;
  logic [63:0] hc_r, hc_nxt;
  logic        og_r, og_nxt;
  logic        fw_r, fw_nxt;
  logic [1:0]  enc_r, enc_nxt;

  logic [1:0]     n;
  logic           do_start;
  logic [63:0]    dig;
  pdp_pkg::desc_t d0, d1, dsc;
  pdp_pkg::lk_t   lk;

  assign dig = {60'd0, ch[3:0] - 4'd0};
  assign lk  = pdp_pkg::lookup(ch);

  always_comb begin
    ph_nxt = ph_r; hk_nxt = hk_r; hs_nxt = hs_r; hb_nxt = hb_r; hw_nxt = hw_r;
    hck_nxt = hck_r; hc_nxt = hc_r; og_nxt = og_r; fw_nxt = fw_r; enc_nxt = enc_r;
    n = 2'd0; d0 = '0; d1 = '0; dsc = '0; do_start = 1'b0;
    if (cmd) begin
      if (ph_r == pdp_pkg::PH_MODS || ph_r == pdp_pkg::PH_DIGITS) begin
        if (enc_nxt == pdp_pkg::ENC_START) enc_nxt = pdp_pkg::ENC_ASCII;
        if (hk_r == pdp_pkg::K_UTF8) begin
          if (enc_nxt == pdp_pkg::ENC_ASCII) enc_nxt = pdp_pkg::ENC_UTF8;
        end else if (hk_r != pdp_pkg::K_UU && hk_r != pdp_pkg::K_MIME &&
                     hk_r != pdp_pkg::K_B64) begin
          enc_nxt = pdp_pkg::ENC_BIN;
        end
        d0 = pdp_pkg::mk(pdp_pkg::ST_OK, hk_r, hs_r, hb_r, hw_r, hck_r, hc_r, enc_nxt);
        n = 2'd1;
      end
      if (enc_nxt == pdp_pkg::ENC_START) enc_nxt = pdp_pkg::ENC_ASCII;
      dsc = pdp_pkg::mk(pdp_pkg::ST_OK, pdp_pkg::K_END, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0,
                        enc_nxt);
      if (n == 2'd0) d0 = dsc; else d1 = dsc;
      n = n + 2'd1;
      ph_nxt = pdp_pkg::PH_IDLE;
      enc_nxt = pdp_pkg::ENC_START;
    end else if (ph_r == pdp_pkg::PH_ERROR) begin
      n = 2'd0;
    end else if (ph_r == pdp_pkg::PH_COMMENT) begin
      if (ch == 8'h0a) do_start = 1'b1;
    end else if (ph_r == pdp_pkg::PH_DIGITS && ch >= "0" && ch <= "9") begin
      if (hc_r > pdp_pkg::CNT_LIMIT || (hc_r == pdp_pkg::CNT_LIMIT && dig > 64'd5)) begin
        if (enc_nxt == pdp_pkg::ENC_START) enc_nxt = pdp_pkg::ENC_ASCII;
        d0 = pdp_pkg::mk(pdp_pkg::ST_TOO_BIG, 5'd0, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0,
                         enc_nxt);
        n = 2'd1;
        ph_nxt = pdp_pkg::PH_ERROR;
      end else begin
        hc_nxt = (hc_r << 3) + (hc_r << 1) + dig;
      end
    end else if (ph_r == pdp_pkg::PH_MODS && (ch == "_" || ch == "!")) begin
      if (hk_r != pdp_pkg::K_INT || fw_r || hw_r < pdp_pkg::W_16) begin
        if (enc_nxt == pdp_pkg::ENC_START) enc_nxt = pdp_pkg::ENC_ASCII;
        d0 = pdp_pkg::mk(pdp_pkg::ST_BANG, 5'd0, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_nxt);
        n = 2'd1;
        ph_nxt = pdp_pkg::PH_ERROR;
      end else if (hw_r == pdp_pkg::W_16) hw_nxt = pdp_pkg::W_SHORT;
      else if (hw_r == pdp_pkg::W_32) hw_nxt = pdp_pkg::W_LONG;
      else if (hw_r == pdp_pkg::W_64) hw_nxt = pdp_pkg::W_LL;
    end else if (ph_r == pdp_pkg::PH_MODS && (ch == "<" || ch == ">")) begin
      if (og_r) begin
        if (enc_nxt == pdp_pkg::ENC_START) enc_nxt = pdp_pkg::ENC_ASCII;
        d0 = pdp_pkg::mk(pdp_pkg::ST_DBL_ORDER, 5'd0, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0,
                         enc_nxt);
        n = 2'd1;
        ph_nxt = pdp_pkg::PH_ERROR;
      end else begin
        hb_nxt = (ch == "<") ? pdp_pkg::BO_LITTLE : pdp_pkg::BO_BIG;
        og_nxt = 1'b1;
      end
    end else if (ph_r == pdp_pkg::PH_MODS && ch >= "0" && ch <= "9") begin
      hck_nxt = pdp_pkg::CK_FIXED;
      hc_nxt = dig;
      ph_nxt = pdp_pkg::PH_DIGITS;
    end else if (ph_r == pdp_pkg::PH_MODS || ph_r == pdp_pkg::PH_DIGITS) begin
      if (ph_r == pdp_pkg::PH_MODS && ch == "*") begin
        hc_nxt = 64'd0;
        hck_nxt = pdp_pkg::CK_MAX;
        case (hk_r)
          pdp_pkg::K_NULL, pdp_pkg::K_BACK:
            hck_nxt = mode_r ? pdp_pkg::CK_MAX : pdp_pkg::CK_FIXED;
          pdp_pkg::K_MOVE: hck_nxt = mode_r ? pdp_pkg::CK_REL : pdp_pkg::CK_FIXED;
          pdp_pkg::K_UU: hck_nxt = pdp_pkg::CK_FIXED;
          pdp_pkg::K_FIXSTR: begin
            if (!mode_r) begin
              hck_nxt = pdp_pkg::CK_FIXED;
              hc_nxt = 64'd1;
            end
          end
          pdp_pkg::K_MIME, pdp_pkg::K_B64: begin
            hck_nxt = pdp_pkg::CK_FIXED;
            hc_nxt = 64'd1;
          end
          default: hck_nxt = pdp_pkg::CK_MAX;
        endcase
      end else begin
        do_start = 1'b1;
      end
      if (enc_nxt == pdp_pkg::ENC_START) enc_nxt = pdp_pkg::ENC_ASCII;
      if (hk_r == pdp_pkg::K_UTF8) begin
        if (enc_nxt == pdp_pkg::ENC_ASCII) enc_nxt = pdp_pkg::ENC_UTF8;
      end else if (hk_r != pdp_pkg::K_UU && hk_r != pdp_pkg::K_MIME &&
                   hk_r != pdp_pkg::K_B64) begin
        enc_nxt = pdp_pkg::ENC_BIN;
      end
      d0 = pdp_pkg::mk(pdp_pkg::ST_OK, hk_r, hs_r, hb_r, hw_r, hck_nxt, hc_nxt, enc_nxt);
      n = 2'd1;
      ph_nxt = pdp_pkg::PH_IDLE;
    end else begin
      do_start = 1'b1;
    end

    if (do_start) begin
      ph_nxt = pdp_pkg::PH_IDLE;
      if (ch == " " || ch == 8'h09 || ch == 8'h0a || ch == 8'h0b || ch == 8'h0c ||
          ch == 8'h0d || ch == "#" || ch == "%" || !lk.ok) begin
        if (enc_nxt == pdp_pkg::ENC_START) enc_nxt = pdp_pkg::ENC_ASCII;
        if (ch == "#") begin
          dsc = pdp_pkg::mk(pdp_pkg::ST_OK, pdp_pkg::K_COMMENT, 2'd0, 3'd0, 4'd0, 2'd0,
                            64'd0, enc_nxt);
          ph_nxt = pdp_pkg::PH_COMMENT;
        end else if (ch == "%") begin
          dsc = pdp_pkg::mk(pdp_pkg::ST_UNSUP, 5'd0, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0,
                            enc_nxt);
          ph_nxt = pdp_pkg::PH_ERROR;
        end else if (!lk.ok && ch != " " && (ch < 8'h09 || ch > 8'h0d)) begin
          dsc = pdp_pkg::mk(pdp_pkg::ST_UNKNOWN, 5'd0, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0,
                            enc_nxt);
          ph_nxt = pdp_pkg::PH_ERROR;
        end else begin
          dsc = pdp_pkg::mk(pdp_pkg::ST_OK, pdp_pkg::K_SPACE, 2'd0, 3'd0, 4'd0, 2'd0,
                            64'd0, enc_nxt);
        end
        if (n == 2'd0) d0 = dsc; else d1 = dsc;
        n = n + 2'd1;
      end else begin
        hk_nxt = lk.k; hs_nxt = lk.s; hb_nxt = lk.b; hw_nxt = lk.w; fw_nxt = lk.f;
        og_nxt = 1'b0;
        hck_nxt = pdp_pkg::CK_FIXED;
        hc_nxt = (mode_r && lk.k == pdp_pkg::K_MOVE) ? 64'd0 : 64'd1;
        ph_nxt = pdp_pkg::PH_MODS;
      end
    end
  end

  assign push     = acc && (n != 2'd0);
  assign push_ent = '{d0: d0, d1: d1, two: n[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      ph_r <= pdp_pkg::PH_IDLE;
      hk_r <= '0; hs_r <= '0; hb_r <= '0; hw_r <= '0; hck_r <= '0; hc_r <= '0;
      og_r <= 1'b0; fw_r <= 1'b0;
      enc_r <= pdp_pkg::ENC_START;
    end else begin
      if (cfg_valid) mode_r <= cfg_data;
      if (acc) begin
        ph_r <= ph_nxt; hk_r <= hk_nxt; hs_r <= hs_nxt; hb_r <= hb_nxt; hw_r <= hw_nxt;
        hck_r <= hck_nxt; hc_r <= hc_nxt; og_r <= og_nxt; fw_r <= fw_nxt;
        enc_r <= enc_nxt;
      end
    end
  end

endmodule

// File: design/pdp_queue.sv
module pdp_queue #(
  parameter int DEPTH = pdp_pkg::QDEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pdp_pkg::entry_t push_ent,
  input  logic            pop,
  output pdp_pkg::entry_t pop_ent,
  output logic            nonempty,
  output logic            full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pdp_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign nonempty = cnt_r != '0;
  assign full     = cnt_r == CW'(DEPTH);
  assign pop_ent  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CW'(1)) else $error("push lost");

endmodule

// File: design/pdp_back.sv
module pdp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  pdp_pkg::entry_t q_ent,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [87:0]     out_tdata,
  output logic            out_tlast
);

  logic            busy_r;
  logic            second_r;
  pdp_pkg::entry_t ent_r;
  pdp_pkg::desc_t  cur;
  logic            fire;

  assign cur        = second_r ? ent_r.d1 : ent_r.d0;
  assign out_tvalid = busy_r;
  assign out_tlast  = second_r || !ent_r.two;
  assign out_tdata  = {3'd0, cur.encoding, cur.count, cur.count_kind, cur.width_code,
                       cur.byte_order, cur.signedness, cur.kind, cur.status};
  assign fire       = busy_r && out_tready;
  assign pop        = q_nonempty && (!busy_r || (fire && out_tlast));

  always_ff @(posedge clk) begin
    if (pop) ent_r <= q_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      second_r <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
      second_r <= 1'b0;
    end else if (fire) begin
      if (out_tlast) busy_r <= 1'b0;
      else second_r <= 1'b1;
    end
  end

endmodule

// File: design/pack_template_directive_parser.sv
// Template directive parser.
// in_*  : one template beat per handshake; tuser is cmd (1 = end of template),
//         tdata is the character byte.
// cfg_* : one-bit mode write (0 pack, 1 unpack), always ready; write only while idle.
// out_* : one descriptor per beat; tlast marks the last descriptor of an input beat.
// An input beat is parsed in the cycle it is accepted; its descriptors, if any (one
// or two), enter a QDEPTH-entry queue. The back end registers a queue entry and sends
// one descriptor per cycle while out_tready is high; a descriptor passes through the
// queue and then the back-end entry register. The input side takes one beat per cycle
// while the queue is not full; both descriptors of a beat are sent from one register.
// in_tready drops only when the queue is full; a stalled receiver fills the queue
// and then holds the input side. Reset clears the parser to idle, the encoding to
// start, the mode to pack and empties the queue.
module pack_template_directive_parser #(
  parameter int QDEPTH = pdp_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] cmd
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [7:3] kind, [9:8] signedness, [12:10] byte_order,
  // [16:13] width_code, [18:17] count_kind, [82:19] count, [84:83] encoding
  output logic [87:0] out_tdata,
  output logic        out_tlast
);

  logic            acc, push, pop, q_nonempty, q_full;
  pdp_pkg::entry_t push_ent, q_ent;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  pdp_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_data, .acc,
    .cmd(in_tuser), .ch(in_tdata), .push, .push_ent
  );

  pdp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .push, .push_ent, .pop, .pop_ent(q_ent),
    .nonempty(q_nonempty), .full(q_full)
  );

  pdp_back u_back (
    .clk, .rst_n, .q_nonempty, .q_ent, .pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule
